// ----- rtl/dual_queue_timeslice_scheduler_top_macros.svh -----
// Assertion macros for the dual-queue time-slice scheduler.
// Used by dual_queue_timeslice_scheduler_top; expects clock and reset in scope.
`ifndef DUAL_QUEUE_TIMESLICE_SCHEDULER_TOP_MACROS_SVH
`define DUAL_QUEUE_TIMESLICE_SCHEDULER_TOP_MACROS_SVH

// Checked outside reset only
`define DQTS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included
`define DQTS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- rtl/dqts_pkg.sv -----
// Shared types and constants of the dual-queue time-slice scheduler.
// No dependencies; imported by dual_queue_timeslice_scheduler_top.
package dqts_pkg;

   localparam int NUM_CPUS   = 8;
   localparam int TASK_SLOTS = 64;

   localparam int CPU_W   = $clog2(NUM_CPUS);
   localparam int TASK_W  = $clog2(TASK_SLOTS);
   localparam int HOME_W  = CPU_W + 1;
   localparam int CUR_W   = TASK_W + 1;
   localparam int QID_W   = CPU_W + 1;
   localparam int CNT_W   = TASK_W + 1;
   localparam int QADDR_W = QID_W + TASK_W;
   localparam int NUM_Q   = 2 * NUM_CPUS;
   localparam int QDEPTH  = NUM_Q * TASK_SLOTS;

   localparam int TYPE_W  = 4;
   localparam int SLICE_W = 32;
   localparam int RUN_W   = 64;
   localparam int IN_W    = 80;
   localparam int OUT_W   = 16;

   localparam logic [SLICE_W-1:0] SLICE_RESET = 32'd5000000;

   localparam logic [1:0] ST_BLOCKED  = 2'd0;
   localparam logic [1:0] ST_RUNNABLE = 2'd1;
   localparam logic [1:0] ST_QUEUED   = 2'd2;
   localparam logic [1:0] ST_ONCPU    = 2'd3;

   localparam logic [TYPE_W-1:0] EV_NEW       = 4'd0;
   localparam logic [TYPE_W-1:0] EV_WAKEUP    = 4'd1;
   localparam logic [TYPE_W-1:0] EV_DEPARTED  = 4'd2;
   localparam logic [TYPE_W-1:0] EV_DEAD      = 4'd3;
   localparam logic [TYPE_W-1:0] EV_YIELD     = 4'd4;
   localparam logic [TYPE_W-1:0] EV_BLOCKED   = 4'd5;
   localparam logic [TYPE_W-1:0] EV_PREEMPTED = 4'd6;
   localparam logic [TYPE_W-1:0] EV_TICK      = 4'd7;
   localparam logic [TYPE_W-1:0] EV_SCHEDULE  = 4'd8;
   localparam logic [TYPE_W-1:0] EV_COMMIT    = 4'd9;
   localparam logic [TYPE_W-1:0] EV_SWITCHTO  = 4'd10;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_ILLEGAL = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   localparam logic [HOME_W-1:0] NO_CPU  = HOME_W'(NUM_CPUS);
   localparam logic [CUR_W-1:0]  NO_TASK = CUR_W'(TASK_SLOTS);

   typedef struct packed {
      logic [1:0]         st;
      logic [HOME_W-1:0]  home;
      logic               boost;
      logic [SLICE_W-1:0] slice;
   } task_word_type;

   localparam task_word_type TASK_RESET = '{st: ST_BLOCKED, home: NO_CPU,
                                            boost: 1'b0, slice: '0};

   typedef enum logic [17:0] {
      S_IDLE     = 18'h00001,
      S_LOAD     = 18'h00002,
      S_DECIDE   = 18'h00004,
      S_FIND_RD  = 18'h00008,
      S_FIND_CMP = 18'h00010,
      S_APPLY    = 18'h00020,
      S_ERASE_RD = 18'h00040,
      S_ERASE_WR = 18'h00080,
      S_PUSH_INI = 18'h00100,
      S_PUSH     = 18'h00200,
      S_PUSH_WR  = 18'h00400,
      S_TICK2    = 18'h00800,
      S_SC_SWAP  = 18'h01000,
      S_SC_POP   = 18'h02000,
      S_POP_DATA = 18'h04000,
      S_POP_TRD  = 18'h08000,
      S_POP_TWR  = 18'h10000,
      S_DONE     = 18'h20000
   } state_type;

endpackage

// ----- rtl/dual_queue_timeslice_scheduler_top.sv -----
// Per-CPU scheduler with an active and an expired queue per CPU (FIFO, but boosted tasks enter at the head).
// Depends on dqts_pkg and dual_queue_timeslice_scheduler_top_macros.svh.
//
// Usage:
//   req_* carries one task event, tick, schedule request or commit per transfer;
//   rsp_* returns exactly one result per event, in order. csr_* writes the
//   fresh slice length and is always ready; write it only while idle.
// Sequencing:
//   A small sequencer drives one queue RAM port (one read, one write a cycle)
//   and one task-state RAM. A queue walk reads and compares each entry
//   searched, and reads and writes each entry shifted on an erase or a front
//   insert. req_tready is high only between events.
// Reset:
//   Queues empty, all slots blocked with no home CPU, no task on any CPU,
//   slice register 5000000. Slot state is cleared at once by per-slot valid
//   bits, so no clearing pass is needed.
// Stall:
//   A finished result waits in the output register; the next event is taken
//   and worked on meanwhile and holds in its final cycle until rsp frees.
`include "dual_queue_timeslice_scheduler_top_macros.svh"

module dual_queue_timeslice_scheduler_top
   import dqts_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // task_id[5:0], cpu_id[8:6], runnable[9], deferrable[10], from_switchto[11],
   // runtime_ns[75:12], commit_ok[76], zero fill[79:77]
   input  logic [IN_W-1:0]   req_tdata,
   // req_type[3:0]
   input  logic [TYPE_W-1:0] req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // status[1:0], pick_valid[2], pick_task[8:3], assigned_cpu[11:9],
   // ping_valid[12], ping_cpu[15:13]
   output logic [OUT_W-1:0]  rsp_tdata,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [SLICE_W-1:0] csr_wdata
);

   state_type state_ff, state_in;

   logic [TYPE_W-1:0]  rt_ff, rt_in;
   logic [TASK_W-1:0]  tsel_ff, tsel_in;
   logic [CPU_W-1:0]   cpu_ff, cpu_in;
   logic               runnable_ff, runnable_in;
   logic               defer_ff, defer_in;
   logic               fs_ff, fs_in;
   logic               ok_ff, ok_in;
   logic [RUN_W-1:0]   runtime_ff, runtime_in;

   logic [1:0]         status_ff, status_in;
   logic               pv_ff, pv_in;
   logic [TASK_W-1:0]  pick_ff, pick_in;
   logic [CPU_W-1:0]   asg_ff, asg_in;
   logic               pgv_ff, pgv_in;
   logic [CPU_W-1:0]   pg_ff, pg_in;

   logic               do_er_ff, do_er_in;
   logic               do_ps_ff, do_ps_in;
   logic [QID_W-1:0]   er_q_ff, er_q_in;
   logic [CNT_W-1:0]   ep_ff, ep_in;
   logic [QID_W-1:0]   ps_q_ff, ps_q_in;
   logic               ps_boost_ff, ps_boost_in;
   logic [CNT_W-1:0]   pp_ff, pp_in;
   logic               fhalf_ff, fhalf_in;
   logic [CNT_W-1:0]   fp_ff, fp_in;
   logic [RUN_W-1:0]   el_ff, el_in;

   logic [CNT_W-1:0]   cnt_ff  [NUM_Q];
   logic [CNT_W-1:0]   cnt_in  [NUM_Q];
   logic               asel_ff [NUM_CPUS];
   logic               asel_in [NUM_CPUS];
   logic [CUR_W-1:0]   cur_ff  [NUM_CPUS];
   logic [CUR_W-1:0]   cur_in  [NUM_CPUS];
   logic               pre_ff  [NUM_CPUS];
   logic               pre_in  [NUM_CPUS];
   logic               tval_ff [TASK_SLOTS];
   logic [CPU_W-1:0]   rr_ff, rr_in;
   logic [SLICE_W-1:0] cfg_ff, cfg_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]   rsp_data_ff, rsp_data_in;

   logic [TASK_W-1:0]  qmem  [QDEPTH];
   task_word_type      tmem  [TASK_SLOTS];
   logic [RUN_W-1:0]   lrmem [TASK_SLOTS];
   logic [TASK_W-1:0]  qrd_ff;
   task_word_type      tmq_ff;
   logic               tvq_ff;
   logic [RUN_W-1:0]   lrq_ff;

   logic               q_we;
   logic [QADDR_W-1:0] q_waddr;
   logic [TASK_W-1:0]  q_wdata;
   logic [QADDR_W-1:0] q_raddr;
   logic               t_we;
   logic               t_clr;
   task_word_type      t_wdata;
   logic               lr_we;

   logic [TASK_W-1:0]  req_task;
   logic [CPU_W-1:0]   req_cpu;

   assign req_task   = req_tdata[5:0];
   assign req_cpu    = req_tdata[8:6];
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   always_comb begin
      task_word_type    tw;
      task_word_type    wd;
      logic [CPU_W-1:0] hc;
      logic             hok;
      logic [QID_W-1:0] qa_h;
      logic [QID_W-1:0] qa_c;
      logic [QID_W-1:0] qe_c;
      logic [QID_W-1:0] qa_rr;
      logic [QID_W-1:0] qsel;
      logic [QID_W-1:0] fq;
      logic [CUR_W-1:0] cur_c;
      logic             cur_ok;
      logic             on_ok;
      logic             fs_eff;
      logic             legal;
      logic             ca;
      logic             cb;
      logic [CPU_W:0]   rr_inc;
      logic [CPU_W-1:0] rr_nx;
      logic [CNT_W-1:0] ep1;
      logic [CNT_W-1:0] pp1;

      state_in    = state_ff;
      rt_in       = rt_ff;
      tsel_in     = tsel_ff;
      cpu_in      = cpu_ff;
      runnable_in = runnable_ff;
      defer_in    = defer_ff;
      fs_in       = fs_ff;
      ok_in       = ok_ff;
      runtime_in  = runtime_ff;
      status_in   = status_ff;
      pv_in       = pv_ff;
      pick_in     = pick_ff;
      asg_in      = asg_ff;
      pgv_in      = pgv_ff;
      pg_in       = pg_ff;
      do_er_in    = do_er_ff;
      do_ps_in    = do_ps_ff;
      er_q_in     = er_q_ff;
      ep_in       = ep_ff;
      ps_q_in     = ps_q_ff;
      ps_boost_in = ps_boost_ff;
      pp_in       = pp_ff;
      fhalf_in    = fhalf_ff;
      fp_in       = fp_ff;
      el_in       = el_ff;
      cnt_in      = cnt_ff;
      asel_in     = asel_ff;
      cur_in      = cur_ff;
      pre_in      = pre_ff;
      rr_in       = rr_ff;
      cfg_in      = csr_valid ? csr_wdata : cfg_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;

      q_we    = 1'b0;
      q_waddr = '0;
      q_wdata = tsel_ff;
      q_raddr = '0;
      t_we    = 1'b0;
      t_clr   = 1'b0;
      lr_we   = 1'b0;

      tw     = tvq_ff ? tmq_ff : TASK_RESET;
      wd     = tw;
      t_wdata = tw;
      hc     = tw.home[CPU_W-1:0];
      hok    = tw.home < NO_CPU;
      qa_h   = {hc, asel_ff[hc]};
      qa_c   = {cpu_ff, asel_ff[cpu_ff]};
      qe_c   = {cpu_ff, ~asel_ff[cpu_ff]};
      qa_rr  = {rr_ff, asel_ff[rr_ff]};
      qsel   = qa_h;
      fq     = {hc, fhalf_ff};
      cur_c  = cur_ff[cpu_ff];
      cur_ok = cur_c < NO_TASK;
      on_ok  = (tw.st == ST_ONCPU) && hok && (cur_ff[hc] == {1'b0, tsel_ff});
      fs_eff = fs_ff && (rt_ff != EV_SWITCHTO);
      legal  = 1'b0;
      ca     = 1'b0;
      cb     = 1'b0;
      rr_inc = {1'b0, rr_ff} + (CPU_W+1)'(1);
      rr_nx  = (rr_inc >= (CPU_W+1)'(NUM_CPUS)) ? '0 : rr_inc[CPU_W-1:0];
      ep1    = ep_ff + CNT_W'(1);
      pp1    = pp_ff - CNT_W'(1);

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               rt_in       = req_tuser;
               cpu_in      = req_cpu;
               tsel_in     = (req_tuser == EV_TICK || req_tuser == EV_SCHEDULE) ?
                             cur_ff[req_cpu][TASK_W-1:0] : req_task;
               runnable_in = req_tdata[9];
               defer_in    = req_tdata[10];
               fs_in       = req_tdata[11];
               runtime_in  = req_tdata[75:12];
               ok_in       = req_tdata[76];
               status_in   = STATUS_OK;
               pv_in       = 1'b0;
               pick_in     = '0;
               asg_in      = '0;
               pgv_in      = 1'b0;
               pg_in       = '0;
               do_er_in    = 1'b0;
               do_ps_in    = 1'b0;
               state_in    = S_LOAD;
            end
         end

         S_LOAD: state_in = S_DECIDE;

         S_DECIDE: begin
            state_in = S_DONE;
            unique case (rt_ff)
               EV_NEW, EV_WAKEUP: begin
                  if (tw.st != ST_BLOCKED || (rt_ff == EV_NEW && tw.home != NO_CPU)) begin
                     status_in = STATUS_ILLEGAL;
                  end else if (rt_ff == EV_NEW && !runnable_ff) begin
                     t_clr = 1'b1;
                  end else begin
                     qsel = hok ? qa_h : qa_rr;
                     if (cnt_ff[qsel] >= CNT_W'(TASK_SLOTS)) begin
                        status_in = STATUS_FULL;
                     end else begin
                        if (rt_ff == EV_NEW) begin
                           wd.boost = 1'b0;
                           wd.slice = '0;
                        end else begin
                           wd.boost = ~defer_ff;
                        end
                        wd.st = ST_QUEUED;
                        if (!hok) begin
                           wd.home = {1'b0, rr_ff};
                           rr_in   = rr_nx;
                           asg_in  = rr_ff;
                           pgv_in  = 1'b1;
                           pg_in   = rr_ff;
                        end
                        t_we        = 1'b1;
                        t_wdata     = wd;
                        ps_q_in     = qsel;
                        ps_boost_in = wd.boost;
                        do_ps_in    = 1'b1;
                        state_in    = S_PUSH_INI;
                     end
                  end
               end
               EV_DEAD: begin
                  if (tw.st != ST_BLOCKED) begin
                     status_in = STATUS_ILLEGAL;
                  end else begin
                     t_clr = 1'b1;
                  end
               end
               EV_DEPARTED, EV_YIELD, EV_PREEMPTED, EV_BLOCKED, EV_SWITCHTO: begin
                  if ((rt_ff == EV_YIELD || rt_ff == EV_PREEMPTED) && !hok) begin
                     status_in = STATUS_ILLEGAL;
                  end else if (tw.st == ST_QUEUED) begin
                     if (hok) begin
                        fhalf_in = 1'b0;
                        fp_in    = '0;
                        state_in = S_FIND_RD;
                     end else begin
                        status_in = STATUS_ILLEGAL;
                     end
                  end else begin
                     if (tw.st == ST_ONCPU) begin
                        legal = on_ok;
                     end else if (tw.st == ST_BLOCKED) begin
                        legal = (rt_ff == EV_DEPARTED) || fs_eff;
                     end
                     if (!legal) begin
                        status_in = STATUS_ILLEGAL;
                     end else if ((rt_ff == EV_YIELD || rt_ff == EV_PREEMPTED) &&
                                  cnt_ff[qa_h] >= CNT_W'(TASK_SLOTS)) begin
                        status_in = STATUS_FULL;
                     end else begin
                        state_in = S_APPLY;
                     end
                  end
               end
               EV_TICK: begin
                  if (cur_ok) begin
                     el_in    = runtime_ff - lrq_ff;
                     state_in = S_TICK2;
                  end
               end
               EV_SCHEDULE: begin
                  if (pre_ff[cpu_ff]) begin
                     pre_in[cpu_ff] = 1'b0;
                     if (cur_ok) begin
                        cur_in[cpu_ff] = NO_TASK;
                        wd.st          = ST_QUEUED;
                        t_we           = 1'b1;
                        t_wdata        = wd;
                        ps_q_in        = (tw.slice != '0) ? qa_c : qe_c;
                        ps_boost_in    = tw.boost;
                        do_ps_in       = 1'b1;
                        state_in       = S_PUSH_INI;
                     end else begin
                        state_in = S_SC_SWAP;
                     end
                  end else if (cur_ok) begin
                     pv_in   = 1'b1;
                     pick_in = cur_c[TASK_W-1:0];
                  end else begin
                     state_in = S_SC_SWAP;
                  end
               end
               EV_COMMIT: begin
                  ca = (tw.st == ST_RUNNABLE) && (tw.home == {1'b0, cpu_ff}) &&
                       (cur_c == NO_TASK);
                  cb = (tw.st == ST_ONCPU) && (cur_c == {1'b0, tsel_ff});
                  if (!(ca || cb) || (cb && !ok_ff)) begin
                     status_in = STATUS_ILLEGAL;
                  end else if (ok_ff) begin
                     cur_in[cpu_ff] = {1'b0, tsel_ff};
                     wd.st    = ST_ONCPU;
                     wd.home  = {1'b0, cpu_ff};
                     wd.boost = 1'b0;
                     if (tw.slice == '0) begin
                        wd.slice = cfg_ff;
                     end
                     t_we    = 1'b1;
                     t_wdata = wd;
                     lr_we   = 1'b1;
                  end else if (cnt_ff[qa_c] >= CNT_W'(TASK_SLOTS)) begin
                     status_in = STATUS_FULL;
                  end else begin
                     wd.st       = ST_QUEUED;
                     t_we        = 1'b1;
                     t_wdata     = wd;
                     ps_q_in     = qa_c;
                     ps_boost_in = tw.boost;
                     do_ps_in    = 1'b1;
                     state_in    = S_PUSH_INI;
                  end
               end
               default: status_in = STATUS_ILLEGAL;
            endcase
         end

         S_FIND_RD: begin
            if (fp_ff < cnt_ff[fq]) begin
               q_raddr  = {fq, fp_ff[TASK_W-1:0]};
               state_in = S_FIND_CMP;
            end else if (!fhalf_ff) begin
               fhalf_in = 1'b1;
               fp_in    = '0;
            end else begin
               status_in = STATUS_ILLEGAL;
               state_in  = S_DONE;
            end
         end

         S_FIND_CMP: begin
            if (qrd_ff == tsel_ff) begin
               er_q_in  = fq;
               ep_in    = fp_ff;
               do_er_in = 1'b1;
               state_in = S_APPLY;
            end else begin
               fp_in    = fp_ff + CNT_W'(1);
               state_in = S_FIND_RD;
            end
         end

         S_APPLY: begin
            if (tw.st == ST_ONCPU) begin
               cur_in[hc] = NO_TASK;
            end
            unique case (rt_ff)
               EV_DEPARTED: begin
                  t_clr = 1'b1;
                  if (fs_ff) begin
                     pgv_in = 1'b1;
                     pg_in  = cpu_ff;
                  end
               end
               EV_YIELD, EV_PREEMPTED: begin
                  wd.st = ST_QUEUED;
                  if (rt_ff == EV_PREEMPTED) begin
                     wd.boost = 1'b1;
                  end else begin
                     wd.slice = '0;
                  end
                  t_we        = 1'b1;
                  t_wdata     = wd;
                  ps_q_in     = qa_h;
                  ps_boost_in = wd.boost;
                  do_ps_in    = 1'b1;
                  if (fs_ff) begin
                     pgv_in = 1'b1;
                     pg_in  = cpu_ff;
                  end
               end
               EV_BLOCKED, EV_SWITCHTO: begin
                  wd.st = ST_BLOCKED;
                  if (rt_ff == EV_BLOCKED) begin
                     wd.slice = '0;
                     if (fs_ff) begin
                        pgv_in = 1'b1;
                        pg_in  = cpu_ff;
                     end
                  end
                  t_we    = 1'b1;
                  t_wdata = wd;
               end
               default: ;
            endcase
            if (do_er_ff) begin
               state_in = S_ERASE_RD;
            end else if (do_ps_in) begin
               state_in = S_PUSH_INI;
            end else begin
               state_in = S_DONE;
            end
         end

         S_ERASE_RD: begin
            // close the gap one entry at a time
            if (ep1 < cnt_ff[er_q_ff]) begin
               q_raddr  = {er_q_ff, ep1[TASK_W-1:0]};
               state_in = S_ERASE_WR;
            end else begin
               cnt_in[er_q_ff] = cnt_ff[er_q_ff] - CNT_W'(1);
               state_in = do_ps_ff ? S_PUSH_INI : S_DONE;
            end
         end

         S_ERASE_WR: begin
            q_we     = 1'b1;
            q_waddr  = {er_q_ff, ep_ff[TASK_W-1:0]};
            q_wdata  = qrd_ff;
            ep_in    = ep1;
            state_in = S_ERASE_RD;
         end

         S_PUSH_INI: begin
            pp_in    = cnt_ff[ps_q_ff];
            state_in = S_PUSH;
         end

         S_PUSH: begin
            if (!ps_boost_ff || pp_ff == '0) begin
               q_we            = 1'b1;
               q_waddr         = {ps_q_ff, pp_ff[TASK_W-1:0]};
               cnt_in[ps_q_ff] = cnt_ff[ps_q_ff] + CNT_W'(1);
               state_in        = (rt_ff == EV_SCHEDULE) ? S_SC_SWAP : S_DONE;
            end else begin
               // shift towards the tail to open the head slot
               q_raddr  = {ps_q_ff, pp1[TASK_W-1:0]};
               state_in = S_PUSH_WR;
            end
         end

         S_PUSH_WR: begin
            q_we     = 1'b1;
            q_waddr  = {ps_q_ff, pp_ff[TASK_W-1:0]};
            q_wdata  = qrd_ff;
            pp_in    = pp1;
            state_in = S_PUSH;
         end

         S_TICK2: begin
            if (el_ff >= RUN_W'(tw.slice)) begin
               wd.slice       = '0;
               pre_in[cpu_ff] = 1'b1;
            end else begin
               wd.slice = tw.slice - el_ff[SLICE_W-1:0];
            end
            t_we     = 1'b1;
            t_wdata  = wd;
            lr_we    = 1'b1;
            state_in = S_DONE;
         end

         S_SC_SWAP: begin
            if (cnt_ff[qa_c] == '0 && cnt_ff[qe_c] != '0) begin
               asel_in[cpu_ff] = ~asel_ff[cpu_ff];
            end
            state_in = S_SC_POP;
         end

         S_SC_POP: begin
            if (cnt_ff[qa_c] != '0) begin
               q_raddr  = {qa_c, {TASK_W{1'b0}}};
               er_q_in  = qa_c;
               ep_in    = '0;
               do_er_in = 1'b1;
               do_ps_in = 1'b0;
               state_in = S_POP_DATA;
            end else begin
               state_in = S_DONE;
            end
         end

         S_POP_DATA: begin
            tsel_in  = qrd_ff;
            pv_in    = 1'b1;
            pick_in  = qrd_ff;
            state_in = S_POP_TRD;
         end

         S_POP_TRD: state_in = S_POP_TWR;

         S_POP_TWR: begin
            wd.st    = ST_RUNNABLE;
            t_we     = 1'b1;
            t_wdata  = wd;
            state_in = S_ERASE_RD;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {pg_ff, pgv_ff, asg_ff, pick_ff, pv_ff, status_ff};
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rr_ff        <= '0;
         cfg_ff       <= SLICE_RESET;
         do_er_ff     <= 1'b0;
         do_ps_ff     <= 1'b0;
         for (int i = 0; i < NUM_Q; i++) begin
            cnt_ff[i] <= '0;
         end
         for (int i = 0; i < NUM_CPUS; i++) begin
            asel_ff[i] <= 1'b0;
            cur_ff[i]  <= NO_TASK;
            pre_ff[i]  <= 1'b0;
         end
         for (int i = 0; i < TASK_SLOTS; i++) begin
            tval_ff[i] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rr_ff        <= rr_in;
         cfg_ff       <= cfg_in;
         do_er_ff     <= do_er_in;
         do_ps_ff     <= do_ps_in;
         cnt_ff       <= cnt_in;
         asel_ff      <= asel_in;
         cur_ff       <= cur_in;
         pre_ff       <= pre_in;
         if (t_we) begin
            tval_ff[tsel_ff] <= 1'b1;
         end else if (t_clr) begin
            tval_ff[tsel_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rt_ff       <= rt_in;
      tsel_ff     <= tsel_in;
      cpu_ff      <= cpu_in;
      runnable_ff <= runnable_in;
      defer_ff    <= defer_in;
      fs_ff       <= fs_in;
      ok_ff       <= ok_in;
      runtime_ff  <= runtime_in;
      status_ff   <= status_in;
      pv_ff       <= pv_in;
      pick_ff     <= pick_in;
      asg_ff      <= asg_in;
      pgv_ff      <= pgv_in;
      pg_ff       <= pg_in;
      er_q_ff     <= er_q_in;
      ep_ff       <= ep_in;
      ps_q_ff     <= ps_q_in;
      ps_boost_ff <= ps_boost_in;
      pp_ff       <= pp_in;
      fhalf_ff    <= fhalf_in;
      fp_ff       <= fp_in;
      el_ff       <= el_in;
      rsp_data_ff <= rsp_data_in;
   end

   // queue entries: one write, one registered read a cycle
   always_ff @(posedge clock) begin
      if (q_we) begin
         qmem[q_waddr] <= q_wdata;
      end
      qrd_ff <= qmem[q_raddr];
   end

   // task words and last runtimes, addressed by the selected slot
   always_ff @(posedge clock) begin
      if (t_we) begin
         tmem[tsel_ff] <= t_wdata;
      end
      if (lr_we) begin
         lrmem[tsel_ff] <= runtime_ff;
      end
      tmq_ff <= tmem[tsel_ff];
      tvq_ff <= tval_ff[tsel_ff];
      lrq_ff <= lrmem[tsel_ff];
   end

   `DQTS_ASSERT(a_accept_load, (req_tvalid && req_tready) |=> (state_ff == S_LOAD), "accepted event did not start a load")
   `DQTS_ASSERT(a_push_room, (state_ff == S_PUSH) |-> (cnt_ff[ps_q_ff] < CNT_W'(TASK_SLOTS)), "push into a full queue")
   `DQTS_ASSERT(a_done_hold, (state_ff == S_DONE && rsp_valid_ff && !rsp_tready) |=> (state_ff == S_DONE), "result dropped while output stalled")
   `DQTS_ASSERT_ALWAYS(a_reset_idle, reset |=> (state_ff == S_IDLE && !rsp_valid_ff), "reset did not return to idle")

endmodule
